FILE: rtl/ascii_morse_keyer_assert.svh
// Assertion macros for the Morse keyer checker.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASCII_MORSE_KEYER_ASSERT_SVH
`define ASCII_MORSE_KEYER_ASSERT_SVH

// same-cycle implication
`define AMK_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define AMK_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/amk_pkg.sv
// Shared types, constants and the Morse code table of the keyer.
// No dependencies.
package amk_pkg;

	localparam int CharW    = 8;
	localparam int DitW     = 16;
	localparam int DurW     = 18;
	localparam int PatW     = 6;
	localparam int LenW     = 3;
	localparam logic [DitW-1:0] DitResetMs = 16'd100;
	localparam logic [CharW-1:0] CharSpace = 8'h20;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SYM_ON,
		ST_SYM_OFF,
		ST_CHAR_GAP,
		ST_WORD_GAP,
		ST_WORD_END
	} state_t;

	// pattern is left aligned: bit 5 is the first symbol, 1 = dah
	typedef struct packed {
		logic [LenW-1:0] len;
		logic [PatW-1:0] pat;
	} code_t;

	typedef struct packed {
		logic       load;
		logic       shift;
		logic       emit;
		logic       seg_on;
		logic [1:0] seg_dits;
		logic       seg_last;
	} cmd_t;

	typedef struct packed {
		logic in_space;
		logic in_has_code;
		logic sym_dah;
		logic sym_last;
	} status_t;

	function automatic code_t code_of(input logic [CharW-1:0] c);
		logic [CharW-1:0] u;
		code_t r;
		u = c;
		if (c >= 8'h61 && c <= 8'h7A) begin
			u = c & 8'hDF;
		end
		case (u)
			8'h21:   r = '{3'd6, 6'b101011};
			8'h22:   r = '{3'd6, 6'b010010};
			8'h27:   r = '{3'd6, 6'b011110};
			8'h28:   r = '{3'd5, 6'b101100};
			8'h29:   r = '{3'd6, 6'b101101};
			8'h2C:   r = '{3'd6, 6'b110011};
			8'h2D:   r = '{3'd6, 6'b100001};
			8'h2E:   r = '{3'd6, 6'b010101};
			8'h2F:   r = '{3'd5, 6'b100100};
			8'h30:   r = '{3'd5, 6'b111110};
			8'h31:   r = '{3'd5, 6'b011110};
			8'h32:   r = '{3'd5, 6'b001110};
			8'h33:   r = '{3'd5, 6'b000110};
			8'h34:   r = '{3'd5, 6'b000010};
			8'h35:   r = '{3'd5, 6'b000000};
			8'h36:   r = '{3'd5, 6'b100000};
			8'h37:   r = '{3'd5, 6'b110000};
			8'h38:   r = '{3'd5, 6'b111000};
			8'h39:   r = '{3'd5, 6'b111100};
			8'h3A:   r = '{3'd6, 6'b111000};
			8'h3D:   r = '{3'd5, 6'b100010};
			8'h3F:   r = '{3'd6, 6'b001100};
			8'h40:   r = '{3'd6, 6'b011010};
			8'h41:   r = '{3'd2, 6'b010000};
			8'h42:   r = '{3'd4, 6'b100000};
			8'h43:   r = '{3'd4, 6'b101000};
			8'h44:   r = '{3'd3, 6'b100000};
			8'h45:   r = '{3'd1, 6'b000000};
			8'h46:   r = '{3'd4, 6'b001000};
			8'h47:   r = '{3'd3, 6'b110000};
			8'h48:   r = '{3'd4, 6'b000000};
			8'h49:   r = '{3'd2, 6'b000000};
			8'h4A:   r = '{3'd4, 6'b011100};
			8'h4B:   r = '{3'd3, 6'b101000};
			8'h4C:   r = '{3'd4, 6'b010000};
			8'h4D:   r = '{3'd2, 6'b110000};
			8'h4E:   r = '{3'd2, 6'b100000};
			8'h4F:   r = '{3'd3, 6'b111000};
			8'h50:   r = '{3'd4, 6'b011000};
			8'h51:   r = '{3'd4, 6'b110100};
			8'h52:   r = '{3'd3, 6'b010000};
			8'h53:   r = '{3'd3, 6'b000000};
			8'h54:   r = '{3'd1, 6'b100000};
			8'h55:   r = '{3'd3, 6'b001000};
			8'h56:   r = '{3'd4, 6'b000100};
			8'h57:   r = '{3'd3, 6'b011000};
			8'h58:   r = '{3'd4, 6'b100100};
			8'h59:   r = '{3'd4, 6'b101100};
			8'h5A:   r = '{3'd4, 6'b110000};
			8'h5F:   r = '{3'd6, 6'b001101};
			default: r = '{3'd0, 6'b000000};
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/amk_char_if.sv
// Request channel carrying one ASCII character.
// Depends on amk_pkg.
interface amk_char_if import amk_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CharW-1:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);
endinterface

FILE: rtl/amk_seg_if.sv
// Request channel carrying one key segment.
// Depends on amk_pkg.
interface amk_seg_if import amk_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            key_on;
	logic [DurW-1:0] duration_ms;
	logic            last;

	modport source (output valid, output key_on, output duration_ms, output last, input ready);
	modport sink (input valid, input key_on, input duration_ms, input last, output ready);
endinterface

FILE: rtl/ascii_morse_keyer.sv
// Morse keyer top level: ASCII characters in, timed key segments out.
// Depends on amk_pkg, amk_char_if, amk_seg_if, amk_ctrl and amk_dpath.
//
// chars (sink): one ASCII character per request. segs (source): one key
// segment per request with key_on, duration_ms and last; last marks the
// final segment of a character. dit_ms_we/dit_ms_wdata set the dit length
// in ms (reset value 100); write only while idle.
// A letter with n symbols gives 2n+1 segments: each symbol on (1 or 3
// dits) and 1 dit off, then a 2 dit gap. A space gives 3 dits off and then
// 1 dit off. Any other character without a code gives only the 2 dit gap.
// The controller issues one segment per cycle into a single output
// register while that register is empty or segs.ready is high. The
// accept in idle moves the controller to the first segment state, which
// then writes the first segment into the output register.
// A new character is taken once the last segment of the previous one sits
// in the output register. While a segment waits with segs.ready low, the
// controller holds and the output register keeps its payload. Reset
// empties the output and returns the controller to idle; no clearing pass is needed.
module ascii_morse_keyer import amk_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            dit_ms_we,
	input  logic [DitW-1:0] dit_ms_wdata,
	amk_char_if.sink        chars,
	amk_seg_if.source       segs
);

	cmd_t    cmd;
	status_t status;

	amk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chars.valid),
		.in_ready  (chars.ready),
		.out_valid (segs.valid),
		.out_ready (segs.ready),
		.status    (status),
		.cmd       (cmd)
	);

	amk_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.dit_we      (dit_ms_we),
		.dit_wdata   (dit_ms_wdata),
		.char_code   (chars.char_code),
		.cmd         (cmd),
		.status      (status),
		.key_on      (segs.key_on),
		.duration_ms (segs.duration_ms),
		.last        (segs.last)
	);

endmodule

FILE: rtl/amk_ctrl.sv
// Keyer controller: sequences symbols and gaps, owns the output valid flag.
// Depends on amk_pkg.
module amk_ctrl import amk_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (status.in_space) begin
						state_d = ST_WORD_GAP;
					end else if (status.in_has_code) begin
						state_d = ST_SYM_ON;
					end else begin
						state_d = ST_CHAR_GAP;
					end
				end
			end
			ST_SYM_ON: begin
				if (slot_free) state_d = ST_SYM_OFF;
			end
			ST_SYM_OFF: begin
				if (slot_free) state_d = status.sym_last ? ST_CHAR_GAP : ST_SYM_ON;
			end
			ST_CHAR_GAP: begin
				if (slot_free) state_d = ST_IDLE;
			end
			ST_WORD_GAP: begin
				if (slot_free) state_d = ST_WORD_END;
			end
			ST_WORD_END: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
			end
			ST_SYM_ON: begin
				cmd.emit     = slot_free;
				cmd.seg_on   = 1'b1;
				cmd.seg_dits = status.sym_dah ? 2'd3 : 2'd1;
			end
			ST_SYM_OFF: begin
				cmd.emit     = slot_free;
				cmd.shift    = slot_free;
				cmd.seg_dits = 2'd1;
			end
			ST_CHAR_GAP: begin
				cmd.emit     = slot_free;
				cmd.seg_dits = 2'd2;
				cmd.seg_last = 1'b1;
			end
			ST_WORD_GAP: begin
				cmd.emit     = slot_free;
				cmd.seg_dits = 2'd3;
			end
			ST_WORD_END: begin
				cmd.emit     = slot_free;
				cmd.seg_dits = 2'd1;
				cmd.seg_last = 1'b1;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/amk_dpath.sv
// Keyer datapath: code lookup, symbol shifter, dit register, output payload.
// Depends on amk_pkg.
module amk_dpath import amk_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             dit_we,
	input  logic [DitW-1:0]  dit_wdata,
	input  logic [CharW-1:0] char_code,
	input  cmd_t             cmd,
	output status_t          status,
	output logic             key_on,
	output logic [DurW-1:0]  duration_ms,
	output logic             last
);

	logic [DitW-1:0] dit_ms_q;
	logic [PatW-1:0] pat_q;
	logic [LenW-1:0] rem_q;
	logic            key_on_q;
	logic [DurW-1:0] dur_q;
	logic            last_q;
	code_t           code;
	logic [DurW-1:0] dit_x1, dit_x2, dur_d;

	assign code = code_of(char_code);

	assign status.in_space    = (char_code == CharSpace);
	assign status.in_has_code = (code.len != '0);
	assign status.sym_dah     = pat_q[PatW-1];
	assign status.sym_last    = (rem_q == LenW'(1));

	assign dit_x1 = DurW'(dit_ms_q);
	assign dit_x2 = DurW'({dit_ms_q, 1'b0});

	always_comb begin
		case (cmd.seg_dits)
			2'd2:    dur_d = dit_x2;
			2'd3:    dur_d = dit_x1 + dit_x2;
			default: dur_d = dit_x1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dit_ms_q <= DitResetMs;
		end else if (dit_we) begin
			dit_ms_q <= dit_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pat_q <= code.pat;
			rem_q <= code.len;
		end else if (cmd.shift) begin
			pat_q <= {pat_q[PatW-2:0], 1'b0};
			rem_q <= rem_q - LenW'(1);
		end
		if (cmd.emit) begin
			key_on_q <= cmd.seg_on;
			dur_q    <= dur_d;
			last_q   <= cmd.seg_last;
		end
	end

	assign key_on      = key_on_q;
	assign duration_ms = dur_q;
	assign last        = last_q;

endmodule

FILE: rtl/amk_checker.sv
// Port-level checks of the Morse keyer, bound to the top level.
// Depends on amk_pkg and ascii_morse_keyer_assert.svh.
`include "ascii_morse_keyer_assert.svh"

module amk_checker import amk_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            chars_valid,
	input logic            chars_ready,
	input logic            segs_valid,
	input logic            segs_ready,
	input logic            segs_key_on,
	input logic [DurW-1:0] segs_duration_ms,
	input logic            segs_last
);

	`AMK_ASSERT_NEXT(a_seg_hold, segs_valid && !segs_ready, segs_valid && $stable(segs_duration_ms))
	`AMK_ASSERT_NEXT(a_busy_after_accept, chars_valid && chars_ready, !chars_ready)
	`AMK_ASSERT_NOW(a_last_is_gap, segs_valid && segs_last, !segs_key_on)
	`AMK_ASSERT_NEXT(a_tone_then_more, segs_valid && segs_ready && segs_key_on, !chars_ready)

endmodule

bind ascii_morse_keyer amk_checker u_amk_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.chars_valid      (chars.valid),
	.chars_ready      (chars.ready),
	.segs_valid       (segs.valid),
	.segs_ready       (segs.ready),
	.segs_key_on      (segs.key_on),
	.segs_duration_ms (segs.duration_ms),
	.segs_last        (segs.last)
);
